### rtl/ngh_pkg.sv
// Shared types, constants and the byte classifier for the n-gram histogram counter.
// No dependencies; every other file imports this package.
package ngh_pkg;

    localparam int SYMBOL_COUNT = 32;
    localparam int COUNT_WIDTH  = 32;
    localparam int OUT_WIDTH    = 32;

    localparam int SINGLE_DEPTH = SYMBOL_COUNT;
    localparam int PAIR_DEPTH   = SYMBOL_COUNT * SYMBOL_COUNT;
    localparam int TRIPLE_DEPTH = SYMBOL_COUNT * SYMBOL_COUNT * SYMBOL_COUNT;

    localparam int SINGLE_AW = $clog2(SINGLE_DEPTH);
    localparam int PAIR_AW   = $clog2(PAIR_DEPTH);
    localparam int TRIPLE_AW = $clog2(TRIPLE_DEPTH);

    localparam int SYM_W       = 6;
    localparam int INDEX_W     = 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYM_W-1:0] NO_SYMBOL = 6'd63;

    localparam logic [7:0] CHR_LOWER_A = 8'd97;
    localparam logic [7:0] CHR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHR_UPPER_A = 8'd65;
    localparam logic [7:0] CHR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHR_COMMA   = 8'd44;
    localparam logic [7:0] CHR_PERIOD  = 8'd46;
    localparam logic [7:0] CHR_SLASH   = 8'd47;
    localparam logic [7:0] CHR_QUEST   = 8'd63;
    localparam logic [7:0] CHR_SEMI    = 8'd59;
    localparam logic [7:0] CHR_COLON   = 8'd58;
    localparam logic [7:0] CHR_APOS    = 8'd39;

    localparam logic [SYM_W-1:0] SYM_COMMA  = 6'd26;
    localparam logic [SYM_W-1:0] SYM_PERIOD = 6'd27;
    localparam logic [SYM_W-1:0] SYM_SLASH  = 6'd28;
    localparam logic [SYM_W-1:0] SYM_SEMI   = 6'd29;
    localparam logic [SYM_W-1:0] SYM_APOS   = 6'd30;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [OUT_WIDTH-1:0]   out_word_t;

    typedef enum logic [1:0] {
        ACT_FEED  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        TBL_SINGLE = 2'd0,
        TBL_PAIR   = 2'd1,
        TBL_TRIPLE = 2'd2,
        TBL_SKIP   = 2'd3
    } table_sel_t;

    typedef enum logic {
        OP_FEED = 1'b0,
        OP_READ = 1'b1
    } op_kind_t;

    // One word of work for the counter back end.
    typedef struct packed {
        op_kind_t               kind;
        table_sel_t             sel;
        logic                   in_range;
        logic                   bump_single;
        logic                   bump_pair;
        logic                   bump_triple;
        logic [SINGLE_AW-1:0]   addr_single;
        logic [PAIR_AW-1:0]     addr_pair;
        logic [TRIPLE_AW-1:0]   addr_triple;
        logic [PAIR_AW-1:0]     addr_skip;
    } op_t;

    function automatic logic [SYM_W-1:0] classify(input logic [7:0] b);
        logic [SYM_W-1:0] s;
        s = NO_SYMBOL;
        if (b >= CHR_LOWER_A && b <= CHR_LOWER_Z) begin
            s = SYM_W'(b - CHR_LOWER_A);
        end else if (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) begin
            s = SYM_W'(b - CHR_UPPER_A);
        end else begin
            case (b) inside
                CHR_COMMA:            s = SYM_COMMA;
                CHR_PERIOD:           s = SYM_PERIOD;
                CHR_SLASH, CHR_QUEST: s = SYM_SLASH;
                CHR_SEMI, CHR_COLON:  s = SYM_SEMI;
                CHR_APOS:             s = SYM_APOS;
                default:              s = NO_SYMBOL;
            endcase
        end
        return s;
    endfunction

    function automatic logic is_symbol(input logic [SYM_W-1:0] s);
        return int'(s) < SYMBOL_COUNT;
    endfunction

endpackage

### rtl/ngh_front.sv
// Front end: accepts input words, classifies bytes, keeps the symbol history
// and builds counter operations. Depends on ngh_pkg.
module ngh_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic [7:0]              s_char_code,
    input  logic [1:0]              s_table_select,
    input  logic [14:0]             s_entry_index,
    input  logic                    q_full,
    input  logic                    clearing,
    output logic                    push,
    output ngh_pkg::op_t            push_op
);
    import ngh_pkg::*;

    logic [SYM_W-1:0] prev_reg, prev_next;
    logic [SYM_W-1:0] prev2_reg, prev2_next;
    logic [SYM_W-1:0] cur;
    logic             accept;
    logic             cur_ok, p1_ok, p2_ok;
    logic             in_range;

    assign s_ready = !q_full && !clearing;
    assign accept  = s_valid && s_ready;
    assign cur     = classify(s_char_code);
    assign cur_ok  = is_symbol(cur);
    assign p1_ok   = is_symbol(prev_reg);
    assign p2_ok   = is_symbol(prev2_reg);

    always_comb begin
        case (s_table_select)
            TBL_SINGLE: in_range = int'(s_entry_index) < SINGLE_DEPTH;
            TBL_TRIPLE: in_range = int'(s_entry_index) < TRIPLE_DEPTH;
            default:    in_range = int'(s_entry_index) < PAIR_DEPTH;
        endcase
    end

    always_comb begin
        prev_next = prev_reg;
        prev2_next = prev2_reg;
        push = 1'b0;
        push_op = '0;
        push_op.kind = OP_FEED;
        push_op.sel = table_sel_t'(s_table_select);
        if (accept) begin
            unique case (s_action)
                ACT_FEED: begin
                    prev2_next = prev_reg;
                    prev_next = cur_ok ? cur : NO_SYMBOL;
                    push = cur_ok;
                    push_op.bump_single = 1'b1;
                    push_op.bump_pair = p1_ok;
                    push_op.bump_triple = p1_ok && p2_ok;
                    push_op.addr_single = SINGLE_AW'(cur);
                    push_op.addr_pair = PAIR_AW'(int'(prev_reg) * SYMBOL_COUNT + int'(cur));
                    push_op.addr_skip = PAIR_AW'(int'(prev2_reg) * SYMBOL_COUNT + int'(cur));
                    push_op.addr_triple = TRIPLE_AW'((int'(prev2_reg) * SYMBOL_COUNT
                        + int'(prev_reg)) * SYMBOL_COUNT + int'(cur));
                end
                ACT_READ: begin
                    push = 1'b1;
                    push_op.kind = OP_READ;
                    push_op.in_range = in_range;
                    push_op.addr_single = s_entry_index[SINGLE_AW-1:0];
                    push_op.addr_pair = s_entry_index[PAIR_AW-1:0];
                    push_op.addr_skip = s_entry_index[PAIR_AW-1:0];
                    push_op.addr_triple = s_entry_index[TRIPLE_AW-1:0];
                end
                ACT_CLEAR: begin
                    prev_next = NO_SYMBOL;
                    prev2_next = NO_SYMBOL;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= NO_SYMBOL;
            prev2_reg <= NO_SYMBOL;
        end else begin
            prev_reg <= prev_next;
            prev2_reg <= prev2_next;
        end
    end

endmodule

### rtl/ngh_queue.sv
// Short FIFO of counter operations between front and back end.
// Depends on ngh_pkg.
module ngh_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ngh_pkg::op_t    push_op,
    output logic            full,
    input  logic            pop,
    output ngh_pkg::op_t    pop_op,
    output logic            empty
);
    import ngh_pkg::*;

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_CW-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = int'(cnt_reg) == QUEUE_DEPTH;
    assign empty   = cnt_reg == '0;
    assign pop_op  = entry_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_op;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/ngh_back.sv
// Back end: counter memories, clearing sweep, read-modify-write with
// forwarding, and the result buffer. Depends on ngh_pkg.
module ngh_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  ngh_pkg::op_t                q_op,
    output logic                        q_pop,
    output logic                        clearing,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ngh_pkg::OUT_WIDTH-1:0] m_count_value
);
    import ngh_pkg::*;

    localparam count_t COUNT_MAX = '1;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic out_word_t to_out(input count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_WIDTH-1:0];
    endfunction

    count_t mem_single [SINGLE_DEPTH];
    count_t mem_pair   [PAIR_DEPTH];
    count_t mem_triple [TRIPLE_DEPTH];
    count_t mem_skip   [PAIR_DEPTH];

    logic                 clearing_reg;
    logic [TRIPLE_AW-1:0] clr_cnt_reg;

    logic   s1_valid_reg;
    op_t    s1_op_reg;
    count_t rd_single_reg, rd_pair_reg, rd_triple_reg, rd_skip_reg;

    // last write per memory, for forwarding into the next operation
    logic                 fw_single_vld_reg, fw_pair_vld_reg, fw_triple_vld_reg, fw_skip_vld_reg;
    logic [SINGLE_AW-1:0] fw_single_addr_reg;
    logic [PAIR_AW-1:0]   fw_pair_addr_reg, fw_skip_addr_reg;
    logic [TRIPLE_AW-1:0] fw_triple_addr_reg;
    count_t               fw_single_data_reg, fw_pair_data_reg;
    count_t               fw_triple_data_reg, fw_skip_data_reg;

    count_t v_single, v_pair, v_triple, v_skip;
    count_t n_single, n_pair, n_triple, n_skip;
    logic   we_single, we_pair, we_triple;
    logic   s1_read;
    count_t read_val;

    out_word_t  out_data_reg [2];
    logic       out_wptr_reg, out_rptr_reg;
    logic [1:0] out_cnt_reg;
    logic       out_take, out_push;
    logic [2:0] pending;
    logic       read_ok;

    assign clearing = clearing_reg;

    // Admit a read only if the result buffer will have room for it.
    assign out_take = m_valid && m_ready;
    assign s1_read  = s1_valid_reg && (s1_op_reg.kind == OP_READ);
    assign pending  = 3'(out_cnt_reg) + 3'(s1_read) - 3'(out_take);
    assign read_ok  = pending <= 3'd1;
    assign q_pop    = !q_empty && !clearing_reg && ((q_op.kind == OP_FEED) || read_ok);

    always_comb begin
        v_single = (fw_single_vld_reg && fw_single_addr_reg == s1_op_reg.addr_single)
            ? fw_single_data_reg : rd_single_reg;
        v_pair = (fw_pair_vld_reg && fw_pair_addr_reg == s1_op_reg.addr_pair)
            ? fw_pair_data_reg : rd_pair_reg;
        v_triple = (fw_triple_vld_reg && fw_triple_addr_reg == s1_op_reg.addr_triple)
            ? fw_triple_data_reg : rd_triple_reg;
        v_skip = (fw_skip_vld_reg && fw_skip_addr_reg == s1_op_reg.addr_skip)
            ? fw_skip_data_reg : rd_skip_reg;
        n_single = sat_inc(v_single);
        n_pair = sat_inc(v_pair);
        n_triple = sat_inc(v_triple);
        n_skip = sat_inc(v_skip);
        we_single = s1_valid_reg && s1_op_reg.bump_single;
        we_pair = s1_valid_reg && s1_op_reg.bump_pair;
        we_triple = s1_valid_reg && s1_op_reg.bump_triple;
        case (s1_op_reg.sel)
            TBL_SINGLE: read_val = v_single;
            TBL_PAIR:   read_val = v_pair;
            TBL_TRIPLE: read_val = v_triple;
            default:    read_val = v_skip;
        endcase
        if (!s1_op_reg.in_range) begin
            read_val = '0;
        end
        out_push = s1_read;
    end

    // Memories: clearing sweep takes the write port until it finishes.
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            if (int'(clr_cnt_reg) < SINGLE_DEPTH) begin
                mem_single[clr_cnt_reg[SINGLE_AW-1:0]] <= '0;
            end
        end else if (we_single) begin
            mem_single[s1_op_reg.addr_single] <= n_single;
        end
        rd_single_reg <= mem_single[q_op.addr_single];
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            if (int'(clr_cnt_reg) < PAIR_DEPTH) begin
                mem_pair[clr_cnt_reg[PAIR_AW-1:0]] <= '0;
            end
        end else if (we_pair) begin
            mem_pair[s1_op_reg.addr_pair] <= n_pair;
        end
        rd_pair_reg <= mem_pair[q_op.addr_pair];
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem_triple[clr_cnt_reg] <= '0;
        end else if (we_triple) begin
            mem_triple[s1_op_reg.addr_triple] <= n_triple;
        end
        rd_triple_reg <= mem_triple[q_op.addr_triple];
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            if (int'(clr_cnt_reg) < PAIR_DEPTH) begin
                mem_skip[clr_cnt_reg[PAIR_AW-1:0]] <= '0;
            end
        end else if (we_triple) begin
            mem_skip[s1_op_reg.addr_skip] <= n_skip;
        end
        rd_skip_reg <= mem_skip[q_op.addr_skip];
    end

    // Pipeline, forwarding registers, sweep control.
    always_ff @(posedge aclk) begin
        s1_op_reg <= q_op;
        fw_single_addr_reg <= s1_op_reg.addr_single;
        fw_pair_addr_reg <= s1_op_reg.addr_pair;
        fw_triple_addr_reg <= s1_op_reg.addr_triple;
        fw_skip_addr_reg <= s1_op_reg.addr_skip;
        fw_single_data_reg <= n_single;
        fw_pair_data_reg <= n_pair;
        fw_triple_data_reg <= n_triple;
        fw_skip_data_reg <= n_skip;
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            fw_single_vld_reg <= 1'b0;
            fw_pair_vld_reg <= 1'b0;
            fw_triple_vld_reg <= 1'b0;
            fw_skip_vld_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (int'(clr_cnt_reg) == TRIPLE_DEPTH - 1) begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg <= q_pop;
            fw_single_vld_reg <= we_single;
            fw_pair_vld_reg <= we_pair;
            fw_triple_vld_reg <= we_triple;
            fw_skip_vld_reg <= we_triple;
        end
    end

    // Two-entry result buffer.
    assign m_valid       = out_cnt_reg != 2'd0;
    assign m_count_value = out_data_reg[out_rptr_reg];

    always_ff @(posedge aclk) begin
        if (out_push) begin
            out_data_reg[out_wptr_reg] <= to_out(read_val);
        end
        if (!aresetn) begin
            out_wptr_reg <= 1'b0;
            out_rptr_reg <= 1'b0;
            out_cnt_reg <= 2'd0;
        end else begin
            if (out_push) begin
                out_wptr_reg <= !out_wptr_reg;
            end
            if (out_take) begin
                out_rptr_reg <= !out_rptr_reg;
            end
            out_cnt_reg <= out_cnt_reg + 2'(out_push) - 2'(out_take);
        end
    end

endmodule

### rtl/ngram_histogram_counter.sv
// Top level of the character n-gram histogram counter.
// Depends on ngh_pkg, ngh_front, ngh_queue and ngh_back.
//
// The block takes one word per cycle on the s_ channel while s_ready is high: a
// feed classifies a text byte into a symbol and bumps the single, pair, triple
// and skip-pair counters that the recent run of valid symbols calls for; a read
// returns one counter on the m_ channel; a clear drops the symbol history. Feeds,
// reads and clears all sustain one word per cycle while m_ready stays high. Each
// counter bump is a read-modify-write through the counter memories, a registered
// read and then a write, with the last write forwarded so that back-to-back bumps
// of the same counter are exact. A read result passes the queue, the registered
// memory read and the result buffer. After reset the block sweeps every memory
// to zero, one entry per cycle; s_ready stays low until the sweep finishes. Read
// results wait in a two-entry buffer. A stalled m_ channel holds the next read at
// the head of the small operation queue once that buffer fills; words behind it
// wait in the queue, and s_ready drops when the queue is full.
module ngram_histogram_counter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [7:0]                      s_char_code,
    input  logic [1:0]                      s_table_select,
    input  logic [14:0]                     s_entry_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ngh_pkg::OUT_WIDTH-1:0]   m_count_value
);
    import ngh_pkg::*;

    logic q_full, q_empty, q_push, q_pop, clearing;
    op_t  push_op, pop_op;

    // classify and build operations
    ngh_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_char_code    (s_char_code),
        .s_table_select (s_table_select),
        .s_entry_index  (s_entry_index),
        .q_full         (q_full),
        .clearing       (clearing),
        .push           (q_push),
        .push_op        (push_op)
    );

    // hold operations so that front and back stall independently
    ngh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .empty   (q_empty)
    );

    // carry out counter updates and reads
    ngh_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_op          (pop_op),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count_value (m_count_value)
    );

endmodule

### rtl/ngh_checker.sv
// Port-level checker for the n-gram histogram counter, with its bind.
// Depends on ngh_pkg and the top level ngram_histogram_counter.
module ngh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_action,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ngh_pkg::OUT_WIDTH-1:0] m_count_value
);
    import ngh_pkg::*;

    logic [3:0] outstanding_reg;
    logic       read_in, word_out;

    assign read_in  = s_valid && s_ready && (s_action == ACT_READ);
    assign word_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_reg + 4'(read_in) - 4'(word_out);
        end
    end

    // hold the result word while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count_value))
        else $error("result word changed while stalled");

    // the clearing sweep blocks input right after reset
    a_sweep_block: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during clearing sweep");

    // every result word answers an accepted read
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != 4'd0)
        else $error("result word without a pending read");

    // reads in flight never exceed queue, pipeline and buffer capacity
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg <= 4'd7)
        else $error("too many reads in flight");

endmodule

bind ngram_histogram_counter ngh_checker u_chk (.*);
